### sv/lru_key_value_cache_macros.svh
// Assertion macros shared by the checker of the key-value cache.
// Depends on nothing; included by the files that assert.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lkvc implication check failed");

`define LKVC_ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error("lkvc two-cycle check failed");

`define LKVC_ASSERT_NEVER(label, clk, rst_n, bad) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
		else $error("lkvc forbidden condition seen");

`endif

### sv/lkvc_pkg.sv
// Package of the key-value cache: sizes, operation codes and constants.
// Depends on nothing; imported by the cache and its checker.
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

endpackage

### sv/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg.
//
//   channel   handshake             payload
//   request   start, busy           func, lookup_key, write_value
//   result    done                  hit, read_value
//   config    cfg_wen               cfg_wdata
//
// A request is registered when accepted and processed in the following cycle,
// where all slots compare their key in parallel and the ranks update at once.
// A get returns its result through the request register and then the result register; a put returns nothing.
// One request is accepted every cycle; busy stays low.
// Reset clears all slots, the ranks, the fill count and sets capacity to 16.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_key_value_cache
	import lkvc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic signed [KEY_W-1:0] lookup_key,
	input  logic signed [VAL_W-1:0] write_value,
	output logic                    done,
	output logic                    hit,
	output logic signed [VAL_W-1:0] read_value,
	input  logic                    cfg_wen,
	input  logic [CAP_W-1:0]        cfg_wdata
);

	logic [KEY_W-1:0]  key_q [ENTRIES];
	logic [VAL_W-1:0]  val_q [ENTRIES];
	logic [RANK_W-1:0] rank_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]  occ_q;
	logic [CAP_W-1:0]  cap_q;

	logic              vld_s1;
	logic              func_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [VAL_W-1:0]  wval_s1;

	logic              done_q;
	logic              hit_q;
	logic [VAL_W-1:0]  rval_q;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] lru_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] tgt;
	logic               hit_any;
	logic               full;
	logic               fill;
	logic               upd;
	logic               is_put;
	logic [CMP_W-1:0]   eff_cap;
	logic [CNT_W-1:0]   r_sel;
	logic [CNT_W-1:0]   r_eff;
	logic [VAL_W-1:0]   sel_val;

	assign busy = 1'b0;

	always_comb begin
		match = '0;
		lru_vec = '0;
		r_sel = '0;
		sel_val = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_s1);
			lru_vec[i] = valid_q[i] && (CNT_W'(rank_q[i]) == (occ_q - CNT_W'(1)));
		end
		free_vec = ~valid_q & (valid_q + ENTRIES'(1));
		hit_any = |match;
		is_put = (func_s1 == FUNC_PUT);

		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
		full = (CMP_W'(occ_q) >= eff_cap);

		fill = 1'b0;
		if (hit_any) begin
			tgt = match;
		end else if (!is_put) begin
			tgt = '0;
		end else if (full) begin
			tgt = lru_vec;
		end else begin
			tgt = free_vec;
			fill = |free_vec;
		end
		upd = vld_s1 && (|tgt);

		for (int i = 0; i < ENTRIES; i++) begin
			if (tgt[i]) begin
				r_sel = r_sel | CNT_W'(rank_q[i]);
			end
			if (match[i]) begin
				sel_val = sel_val | val_q[i];
			end
		end
		r_eff = fill ? occ_q : r_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wen) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			done_q <= vld_s1 && (func_s1 == FUNC_GET);
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1 <= func;
			key_s1 <= lookup_key;
			wval_s1 <= write_value;
		end
		hit_q <= hit_any;
		rval_q <= hit_any ? sel_val : MISS_VALUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (upd) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (tgt[i]) begin
					rank_q[i] <= '0;
					valid_q[i] <= 1'b1;
				end else if (valid_q[i] && (CNT_W'(rank_q[i]) < r_eff)) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
			if (fill) begin
				occ_q <= occ_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (vld_s1 && is_put && tgt[i]) begin
				key_q[i] <= key_s1;
				val_q[i] <= wval_s1;
			end
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign read_value = rval_q;

endmodule

### sv/lkvc_checker.sv
// Port-level checker of the key-value cache and its bind to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_macros.svh.
`include "lru_key_value_cache_macros.svh"

module lkvc_port_checker
	import lkvc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             func,
	input logic             done,
	input logic             hit,
	input logic [VAL_W-1:0] read_value
);

	logic get_acc;
	logic put_acc;

	assign get_acc = start && !busy && (func == FUNC_GET);
	assign put_acc = start && !busy && (func == FUNC_PUT);

	`LKVC_ASSERT_DELAY2(a_get_gives_result, clk, arst_n, get_acc, done)
	`LKVC_ASSERT_DELAY2(a_put_gives_none, clk, arst_n, put_acc, !done)
	`LKVC_ASSERT_IMPLY(a_result_from_get, clk, arst_n, done, $past(get_acc, 2))
	`LKVC_ASSERT_IMPLY(a_miss_value, clk, arst_n, done && !hit, read_value == MISS_VALUE)

endmodule

bind lru_key_value_cache lkvc_port_checker u_lkvc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.func(func),
	.done(done),
	.hit(hit),
	.read_value(read_value)
);
